// ===== sv/sst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and default sizes for the sparse set table.
package sst_pkg;

    localparam int ENTITY_LIMIT_DEF    = 1024;
    localparam int CAPACITY_DEF        = 256;
    localparam int COMPONENT_WIDTH_DEF = 32;

    // Fixed field widths of the request and response
    localparam int ENTITY_W = 10;
    localparam int COMP_W   = 32;
    localparam int COUNT_W  = 9;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        action_t               action;
        logic [ENTITY_W-1:0]   entity;
        logic [COMP_W-1:0]     component;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic                  found;
        logic [COMP_W-1:0]     component_out;
        logic [COUNT_W-1:0]    count;
    } rsp_t;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_DONE = 3'b100
    } state_t;

    // Read and write strobes from the sequencer to the store
    typedef struct packed {
        logic index_rd;
        logic dense_rd;
        logic index_we;
        logic dense_we;
    } mem_ctl_t;

endpackage

// ===== sv/sst_store.sv =====
`timescale 1ns / 1ps
// Sparse index memory and packed dense memories with write forwarding.
module sst_store #(
    parameter int ENTITY_LIMIT    = sst_pkg::ENTITY_LIMIT_DEF,
    parameter int CAPACITY        = sst_pkg::CAPACITY_DEF,
    parameter int COMPONENT_WIDTH = sst_pkg::COMPONENT_WIDTH_DEF,
    localparam int ID_SPACE       = 1 << sst_pkg::ENTITY_W,
    localparam int SPARSE_DEPTH   = (ENTITY_LIMIT < ID_SPACE) ? ENTITY_LIMIT : ID_SPACE,
    localparam int SPARSE_AW      = $clog2(SPARSE_DEPTH),
    localparam int IDX_W          = $clog2(CAPACITY),
    localparam int SW             = (COMPONENT_WIDTH < sst_pkg::COMP_W) ?
                                    COMPONENT_WIDTH : sst_pkg::COMP_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sst_pkg::mem_ctl_t            ctl,
    input  logic [SPARSE_AW-1:0]         index_rd_addr,
    output logic [IDX_W-1:0]             index_rd_data,
    input  logic [SPARSE_AW-1:0]         index_wr_addr,
    input  logic [IDX_W-1:0]             index_wr_data,
    input  logic [IDX_W-1:0]             dense_rd_addr_a,
    input  logic [IDX_W-1:0]             dense_rd_addr_b,
    output logic [SW-1:0]                comp_a,
    output logic [SW-1:0]                comp_b,
    output logic [sst_pkg::ENTITY_W-1:0] ent_a,
    output logic [sst_pkg::ENTITY_W-1:0] ent_b,
    input  logic [IDX_W-1:0]             dense_wr_addr,
    input  logic [SW-1:0]                dense_wr_comp,
    input  logic [sst_pkg::ENTITY_W-1:0] dense_wr_ent
);

    logic [IDX_W-1:0]             index_mem [SPARSE_DEPTH];
    logic [SW-1:0]                comp_mem  [CAPACITY];
    logic [sst_pkg::ENTITY_W-1:0] ent_mem   [CAPACITY];

    logic [IDX_W-1:0]     index_q_reg;
    logic [SPARSE_AW-1:0] rd_addr_reg;
    logic                 fwd_valid_reg;
    logic [SPARSE_AW-1:0] fwd_addr_reg;
    logic [IDX_W-1:0]     fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.index_we)
        begin
            index_mem[index_wr_addr] <= index_wr_data;
        end
        if (ctl.index_rd)
        begin
            index_q_reg <= index_mem[index_rd_addr];
            rd_addr_reg <= index_rd_addr;
        end
    end

    // Last index write is kept so a read in the same cycle sees it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (ctl.index_we)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.index_we)
        begin
            fwd_addr_reg <= index_wr_addr;
            fwd_data_reg <= index_wr_data;
        end
    end

    assign index_rd_data = (fwd_valid_reg && fwd_addr_reg == rd_addr_reg) ?
                           fwd_data_reg : index_q_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.dense_we)
        begin
            comp_mem[dense_wr_addr] <= dense_wr_comp;
            ent_mem[dense_wr_addr]  <= dense_wr_ent;
        end
        if (ctl.dense_rd)
        begin
            comp_a <= comp_mem[dense_rd_addr_a];
            comp_b <= comp_mem[dense_rd_addr_b];
            ent_a  <= ent_mem[dense_rd_addr_a];
            ent_b  <= ent_mem[dense_rd_addr_b];
        end
    end

endmodule

// ===== sv/sparse_set_table_unit.sv =====
`timescale 1ns / 1ps
// Sparse set table: entity ids mapped onto a packed array of component words.
//
// Request channel (req_valid / req_stall / req): one operation per request,
// add, remove, look up or clear all. Response channel (rsp_valid / rsp_stall
// / rsp): exactly one response per request, in request order, carrying the
// status, whether the entity was held beforehand (not set on clear), the component on a lookup
// hit and the entry count after the operation.
// A new request is taken only in idle or as the last one completes. The
// sparse index memory is read at the accepting edge, the dense memories (at
// the held position and at the last entry) in the look step, and the
// decision and all write-backs happen as the decide step completes, where
// the next request may already be taken. The index write of one request and
// the index read of the next share that edge, so the index read is forwarded
// from the last write. The response is registered as the decide step completes.
// A stalled response holds; the unit still takes one further request and
// parks it in its decide step until the response register frees up.
// Reset clears the entry count and control state only: the memories need
// no clearing, as membership is checked against the count and the packed
// entity id.
module sparse_set_table_unit #(
    parameter int ENTITY_LIMIT    = sst_pkg::ENTITY_LIMIT_DEF,
    parameter int CAPACITY        = sst_pkg::CAPACITY_DEF,
    parameter int COMPONENT_WIDTH = sst_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sst_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sst_pkg::rsp_t rsp
);

    localparam int ID_SPACE     = 1 << sst_pkg::ENTITY_W;
    localparam int SPARSE_DEPTH = (ENTITY_LIMIT < ID_SPACE) ? ENTITY_LIMIT : ID_SPACE;
    localparam int SPARSE_AW    = $clog2(SPARSE_DEPTH);
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int SW           = (COMPONENT_WIDTH < sst_pkg::COMP_W) ?
                                  COMPONENT_WIDTH : sst_pkg::COMP_W;
    localparam int CO_W         = (CNT_W < sst_pkg::COUNT_W) ? CNT_W : sst_pkg::COUNT_W;

    sst_pkg::state_t   state_reg, state_next;
    sst_pkg::req_t     req_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  pos_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    sst_pkg::rsp_t     rsp_reg, rsp_next;

    sst_pkg::mem_ctl_t            ctl;
    logic [IDX_W-1:0]             index_rd_data;
    logic [SPARSE_AW-1:0]         index_wr_addr;
    logic [IDX_W-1:0]             index_wr_data;
    logic [SW-1:0]                comp_a, comp_b;
    logic [sst_pkg::ENTITY_W-1:0] ent_a, ent_b;
    logic [IDX_W-1:0]             dense_wr_addr;
    logic [SW-1:0]                dense_wr_comp;
    logic [sst_pkg::ENTITY_W-1:0] dense_wr_ent;

    logic              take, completing;
    logic              in_range, present, full;
    logic              want_index_we, want_dense_we;
    logic [CNT_W-1:0]  count_m1;
    logic [SW-1:0]     req_comp;

    // ---- handshake -------------------------------------------------------
    // The decide step completes only once the response register is free.
    assign completing = (state_reg == sst_pkg::S_DONE) && !(rsp_valid_reg && rsp_stall);
    assign req_stall  = !((state_reg == sst_pkg::S_IDLE) || completing);
    assign take       = req_valid && !req_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sst_pkg::S_IDLE: if (take) state_next = sst_pkg::S_LOOK;
            sst_pkg::S_LOOK: state_next = sst_pkg::S_DONE;
            sst_pkg::S_DONE:
            begin
                if (completing)
                begin
                    state_next = take ? sst_pkg::S_LOOK : sst_pkg::S_IDLE;
                end
            end
            default: state_next = sst_pkg::S_IDLE;
        endcase
    end

    // ---- dense read addresses -------------------------------------------
    // Last entry is read alongside the held position for a swap on remove.
    assign count_m1 = count_reg - 1'b1;
    assign req_comp = req_reg.component[SW-1:0];

    // ---- decide ----------------------------------------------------------
    assign in_range = int'(req_reg.entity) < ENTITY_LIMIT;
    assign full     = count_reg == CNT_W'(CAPACITY);

    // A position taken from a never-written index entry fails the check,
    // so only a genuine match marks the entity as held.
    always_comb
    begin
        present = 1'b0;
        if (in_range && (CNT_W'(pos_reg) < count_reg) && (ent_a == req_reg.entity))
        begin
            present = 1'b1;
        end
    end

    always_comb
    begin
        want_index_we = 1'b0;
        want_dense_we = 1'b0;
        index_wr_addr = req_reg.entity[SPARSE_AW-1:0];
        index_wr_data = count_reg[IDX_W-1:0];
        dense_wr_addr = pos_reg;
        dense_wr_comp = req_comp;
        dense_wr_ent  = req_reg.entity;
        count_next    = count_reg;

        rsp_next               = '0;
        rsp_next.status        = sst_pkg::ST_OK;
        rsp_next.found         = present;

        case (req_reg.action)
            sst_pkg::ACT_ADD:
            begin
                if (present)
                begin
                    // replace component in place
                    want_dense_we = 1'b1;
                end
                else if (!in_range)
                begin
                    rsp_next.status = sst_pkg::ST_ABSENT;
                end
                else if (full)
                begin
                    rsp_next.status = sst_pkg::ST_FULL;
                end
                else
                begin
                    want_dense_we = 1'b1;
                    want_index_we = 1'b1;
                    dense_wr_addr = count_reg[IDX_W-1:0];
                    count_next    = count_reg + 1'b1;
                end
            end
            sst_pkg::ACT_REMOVE:
            begin
                if (present)
                begin
                    // last entry fills the hole, its index follows
                    want_dense_we = 1'b1;
                    dense_wr_comp = comp_b;
                    dense_wr_ent  = ent_b;
                    want_index_we = int'(ent_b) < ENTITY_LIMIT;
                    index_wr_addr = ent_b[SPARSE_AW-1:0];
                    index_wr_data = pos_reg;
                    count_next    = count_m1;
                end
                else
                begin
                    rsp_next.status = sst_pkg::ST_ABSENT;
                end
            end
            sst_pkg::ACT_LOOKUP:
            begin
                if (present)
                begin
                    rsp_next.component_out[SW-1:0] = comp_a;
                end
                else
                begin
                    rsp_next.status = sst_pkg::ST_ABSENT;
                end
            end
            default:
            begin
                // clear all: count only
                rsp_next.found = 1'b0;
                count_next     = '0;
            end
        endcase

        rsp_next.count[CO_W-1:0] = count_next[CO_W-1:0];
    end

    always_comb
    begin
        ctl.index_rd = take;
        ctl.dense_rd = state_reg == sst_pkg::S_LOOK;
        ctl.index_we = completing && want_index_we;
        ctl.dense_we = completing && want_dense_we;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (completing)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // ---- registers -------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sst_pkg::S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (completing)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= req;
        end
        if (state_reg == sst_pkg::S_LOOK)
        begin
            pos_reg <= index_rd_data;
        end
        if (completing)
        begin
            rsp_reg <= rsp_next;
        end
    end

    sst_store #(
        .ENTITY_LIMIT    (ENTITY_LIMIT),
        .CAPACITY        (CAPACITY),
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_store (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .index_rd_addr   (req.entity[SPARSE_AW-1:0]),
        .index_rd_data   (index_rd_data),
        .index_wr_addr   (index_wr_addr),
        .index_wr_data   (index_wr_data),
        .dense_rd_addr_a (index_rd_data),
        .dense_rd_addr_b (count_m1[IDX_W-1:0]),
        .comp_a          (comp_a),
        .comp_b          (comp_b),
        .ent_a           (ent_a),
        .ent_b           (ent_b),
        .dense_wr_addr   (dense_wr_addr),
        .dense_wr_comp   (dense_wr_comp),
        .dense_wr_ent    (dense_wr_ent)
    );

endmodule

// ===== sv/sst_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the sparse set table, bound to the top level.
module sst_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input sst_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input sst_pkg::rsp_t rsp
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // a taken request keeps the unit busy for the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken on consecutive cycles");

    // a held entity never yields an error status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found |-> rsp.status == sst_pkg::ST_OK)
        else $error("found entity with error status");

    // a component is only returned on a hit
    a_comp_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.component_out != '0) |-> rsp.found && rsp.status == sst_pkg::ST_OK)
        else $error("component returned without a hit");

endmodule

bind sparse_set_table_unit sst_checker u_sst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// ===== tb/sv/tb_sparse_set_table_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sparse set table unit, with its own table predictor.
module tb_sparse_set_table_unit;

    import sst_pkg::*;

    localparam int ENTITY_COUNT = ENTITY_LIMIT_DEF;
    localparam int SLOT_COUNT   = CAPACITY_DEF;

    // Tracks the table contents as every accepted request would leave them, and
    // holds the responses those requests must produce, oldest first.
    class sparse_set_tracker;
        logic [7:0]          slot_of_entity [ENTITY_COUNT];
        logic [COMP_W-1:0]   packed_comp    [SLOT_COUNT];
        logic [ENTITY_W-1:0] packed_ent     [SLOT_COUNT];
        int unsigned         entries;
        bit                  written        [ENTITY_COUNT];
        logic [ENTITY_W-1:0] written_ids[$];
        rsp_t                pending_responses[$];
        int                  errors;
        int                  checked;
        int                  per_action [4];
        int                  full_refusals;
        int                  absent_replies;
        int                  peak_entries;

        function new();
            foreach (slot_of_entity[i]) slot_of_entity[i] = '0;
            foreach (packed_comp[i]) packed_comp[i] = '0;
            foreach (packed_ent[i]) packed_ent[i] = '0;
            foreach (written[i]) written[i] = 1'b0;
            foreach (per_action[i]) per_action[i] = 0;
            entries = 0;
            errors = 0;
            checked = 0;
            full_refusals = 0;
            absent_replies = 0;
            peak_entries = 0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // Held only when the recorded slot is live and points back at this id
        function bit holds(logic [ENTITY_W-1:0] id, output int unsigned pos);
            int unsigned p;
            p = slot_of_entity[id];
            pos = p;
            return (p < entries) && (packed_ent[p] == id);
        endfunction

        function void note_request(req_t r);
            int unsigned pos;
            int unsigned last;
            logic [ENTITY_W-1:0] moved;
            bit hit;
            rsp_t e;
            hit = holds(r.entity, pos);
            e.status = ST_OK;
            e.found = hit;
            e.component_out = '0;
            per_action[r.action]++;
            case (r.action)
                ACT_ADD:
                begin
                    if (hit)
                        packed_comp[pos] = r.component;
                    else if (entries >= SLOT_COUNT)
                        e.status = ST_FULL;
                    else
                    begin
                        packed_comp[entries] = r.component;
                        packed_ent[entries] = r.entity;
                        slot_of_entity[r.entity] = 8'(entries);
                        if (!written[r.entity])
                        begin
                            written[r.entity] = 1'b1;
                            written_ids = {written_ids, r.entity};
                        end
                        entries++;
                    end
                end
                ACT_REMOVE:
                begin
                    // swap the last entry into the hole and repoint its index
                    if (hit)
                    begin
                        last = entries - 1;
                        moved = packed_ent[last];
                        packed_comp[pos] = packed_comp[last];
                        packed_ent[pos] = moved;
                        slot_of_entity[moved] = 8'(pos);
                        entries = last;
                    end
                    else
                        e.status = ST_ABSENT;
                end
                ACT_LOOKUP:
                begin
                    if (hit)
                        e.component_out = packed_comp[pos];
                    else
                        e.status = ST_ABSENT;
                end
                ACT_CLEAR:
                begin
                    e.found = 1'b0;
                    entries = 0;
                end
            endcase
            if (e.status == ST_FULL) full_refusals++;
            if (e.status == ST_ABSENT) absent_replies++;
            if (entries > peak_entries) peak_entries = entries;
            e.count = COUNT_W'(entries);
            pending_responses = {pending_responses, e};
        endfunction

        task check_response(rsp_t got);
            rsp_t e;
            if (pending_responses.size() == 0)
            begin
                report("response with no request outstanding");
                return;
            end
            e = pending_responses.pop_front();
            checked++;
            if (got.status !== e.status)
                report($sformatf("status %0d, predicted %0d", got.status, e.status));
            if (got.found !== e.found)
                report($sformatf("found %0b, predicted %0b", got.found, e.found));
            if (got.component_out !== e.component_out)
                report($sformatf("component_out %h, predicted %h",
                                 got.component_out, e.component_out));
            if (got.count !== e.count)
                report($sformatf("count %0d, predicted %0d", got.count, e.count));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    sparse_set_tracker sb = new();

    // Idle behaviour per phase: chance of a gap after each request, and chance
    // per cycle that the receiver starts a stall burst
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit long_hold_due = 1'b0;
    int long_holds = 0;
    int input_held = 0;

    sparse_set_table_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Run limit: far beyond the slowest legal run (every request waiting out a
    // full sender gap and a full receiver burst, plus the long hold)
    initial
    begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver: checks each accepted response, then decides the stall for the
    // next cycle. A long hold is counted down here while the sender carries on.
    initial
    begin : response_side
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                sb.check_response(rsp);
            if (hold_left > 0)
                hold_left--;
            else if (long_hold_due)
            begin
                long_hold_due = 1'b0;
                long_holds++;
                hold_left = 150;
            end
            else if (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct)
                hold_left = $urandom_range(1, 17);
            rsp_stall <= (hold_left > 0);
        end
    end

    // One request: offered until taken, then noted with the predictor; a random
    // gap may follow. The payload never changes while stalled.
    task automatic send(action_t act, logic [ENTITY_W-1:0] id, logic [COMP_W-1:0] word);
        req_t r;
        r.action = act;
        r.entity = id;
        r.component = word;
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
        begin
            input_held++;
            @(posedge clk);
        end
        sb.note_request(r);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Random requests. Remove, look-up and clear only name entities that were
    // added at some point, so only adds read the sparse index unwritten; adds
    // reach fresh ids with the given bias so the table can be filled.
    task automatic random_phase(int n, int w_add, int w_rem, int w_look, int fresh_pct);
        int roll;
        action_t act;
        logic [ENTITY_W-1:0] id;
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(99);
            if (roll < w_add)
                act = ACT_ADD;
            else if (roll < w_add + w_rem)
                act = ACT_REMOVE;
            else if (roll < w_add + w_rem + w_look)
                act = ACT_LOOKUP;
            else
                act = ACT_CLEAR;
            if (act != ACT_ADD && sb.written_ids.size() == 0)
                act = ACT_ADD;
            if (act == ACT_ADD && $urandom_range(99) < fresh_pct)
                id = ENTITY_W'($urandom_range(ENTITY_COUNT - 1));
            else if (sb.entries > 0 && $urandom_range(99) < 70)
                id = sb.packed_ent[$urandom_range(sb.entries - 1)];
            else if (sb.written_ids.size() > 0)
                id = sb.written_ids[$urandom_range(sb.written_ids.size() - 1)];
            else
                id = ENTITY_W'($urandom_range(ENTITY_COUNT - 1));
            send(act, id, $urandom);
        end
    endtask

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, replace, swap-remove with index repair,
        // stale index after a move, remove of the last entry, clear and re-add
        send_idle_pct = 20;
        recv_idle_pct = 5;
        send(ACT_ADD,    10'd0,     32'h0000_0000);
        send(ACT_ADD,    10'd1023,  32'hFFFF_FFFF);
        send(ACT_LOOKUP, 10'd0,     32'hFFFF_FFFF);
        send(ACT_LOOKUP, 10'd1023,  32'h0000_0000);
        send(ACT_ADD,    10'd0,     32'h5A5A_5A5A);
        send(ACT_LOOKUP, 10'd0,     32'h0000_0000);
        send(ACT_ADD,    10'h155,   32'hAAAA_AAAA);
        send(ACT_ADD,    10'h2AA,   32'h5555_5555);
        send(ACT_REMOVE, 10'd0,     32'h0000_0000);
        send(ACT_LOOKUP, 10'h2AA,   32'h0000_0000);
        send(ACT_LOOKUP, 10'd0,     32'h0000_0000);
        send(ACT_REMOVE, 10'd0,     32'hFFFF_FFFF);
        send(ACT_REMOVE, 10'h2AA,   32'h0000_0000);
        send(ACT_LOOKUP, 10'h155,   32'h0000_0000);
        send(ACT_REMOVE, 10'd1023,  32'h0000_0000);
        send(ACT_LOOKUP, 10'd1023,  32'h0000_0000);
        send(ACT_CLEAR,  10'd1023,  32'hFFFF_FFFF);
        send(ACT_LOOKUP, 10'h155,   32'h0000_0000);
        send(ACT_REMOVE, 10'h155,   32'h0000_0000);
        send(ACT_ADD,    10'h155,   32'h1234_5678);
        send(ACT_LOOKUP, 10'h155,   32'h0000_0000);
        send(ACT_CLEAR,  10'd0,     32'h0000_0000);
        send(ACT_CLEAR,  10'h155,   32'h0000_0000);

        // Fill: mostly fresh adds, so the table reaches capacity and full
        // refusals follow
        send_idle_pct = 25;
        recv_idle_pct = 6;
        random_phase(450, 85, 3, 12, 85);

        // Back-pressure: receiver holds off for a long stretch while requests
        // keep coming with no gaps
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold_due = 1'b1;
        random_phase(150, 30, 30, 38, 40);

        // Churn with occasional clears
        send_idle_pct = 30;
        recv_idle_pct = 8;
        random_phase(500, 35, 35, 28, 40);

        // Remove-heavy, slow receiver
        send_idle_pct = 10;
        recv_idle_pct = 15;
        random_phase(200, 20, 50, 28, 40);

        // Tail: no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(120, 35, 35, 28, 40);
        req_valid <= 1'b0;

        while (sb.pending_responses.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d requests: %0d add, %0d remove, %0d look-up, %0d clear; %0d responses checked.",
                 sb.per_action[ACT_ADD] + sb.per_action[ACT_REMOVE] +
                 sb.per_action[ACT_LOOKUP] + sb.per_action[ACT_CLEAR],
                 sb.per_action[ACT_ADD], sb.per_action[ACT_REMOVE],
                 sb.per_action[ACT_LOOKUP], sb.per_action[ACT_CLEAR], sb.checked);
        $display("Peak %0d entries, %0d full refusals, %0d absent replies, input stalled %0d cycles, %0d long hold(s).",
                 sb.peak_entries, sb.full_refusals, sb.absent_replies, input_held, long_holds);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sst_pkg.sv
sv/sst_store.sv
sv/sparse_set_table_unit.sv
sv/sst_checker.sv
tb/sv/tb_sparse_set_table_unit.sv
